/* rtl/bwg3m_pkg.sv */
// Shared types, constants and fixed-point helpers for the banded waveguide core.
package bwg3m_pkg;

  localparam int DEF_DELAY_DEPTH = 8192;
  localparam int DEF_MODE_COUNT  = 3;

  localparam int IN_W      = 16;  // excitation sample, Q1.15
  localparam int Q_W       = 24;  // Q4.20 samples
  localparam int COEF_W    = 18;  // Q2.16 coefficients
  localparam int DELAY_W   = 13;  // delay length field
  localparam int FB_W      = 16;  // feedback gain, unsigned Q0.16
  localparam int CFG_W     = 54;
  localparam int CFG_IDX_W = 3;
  localparam int DIFF_W    = IN_W + 1 + 5;  // (x - x[n-2]) in Q2.20
  localparam int ACC_W     = 48;
  localparam int SUM_W     = 32;

  // modes that the config registers reach
  localparam int CFG_MODES = 3;
  // span of the history loop, from history read through write-back
  localparam int LOOP_CYC  = 4;

  localparam int OUT_DEPTH = 4;
  localparam int OUT_PTR_W = 2;
  localparam int OUT_CNT_W = 3;

  localparam logic [FB_W-1:0] FB_RESET = 16'd65208;

  localparam logic signed [SUM_W-1:0] SAT_HI = 32'sd8388607;
  localparam logic signed [SUM_W-1:0] SAT_LO = -32'sd8388608;
  localparam logic signed [ACC_W-1:0] RND_HALF = 48'sd32768;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE0   = 3'd0,
    CFG_MODE1   = 3'd1,
    CFG_MODE2   = 3'd2,
    CFG_DELAYS  = 3'd3,
    CFG_FB_GAIN = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic vld;
    logic first;
    logic last;
  } mode_ctl_t;

  typedef struct packed {
    logic                  vld;
    logic signed [Q_W-1:0] sample;
  } result_t;

  function automatic logic signed [Q_W-1:0] sat_q(input logic signed [SUM_W-1:0] v);
    logic signed [Q_W-1:0] r;
    if (v > SAT_HI) begin
      r = SAT_HI[Q_W-1:0];
    end else if (v < SAT_LO) begin
      r = SAT_LO[Q_W-1:0];
    end else begin
      r = v[Q_W-1:0];
    end
    return r;
  endfunction

  // 36 fraction bits to 20, round half up
  function automatic logic signed [SUM_W-1:0] round_q(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] t;
    t = (v + RND_HALF) >>> 16;
    return t[SUM_W-1:0];
  endfunction

endpackage

/* rtl/banded_waveguide_three_mode_core.sv */
// Top level: config registers, item sequencer and result queue of the banded waveguide.
//
//  channel  direction  handshake          payload
//  in       input      in_valid/in_stall  in_sample   (Q1.15)
//  out      output     out_valid/out_stall out_sample (Q4.20, saturated)
//  cfg      input      cfg_we             cfg_idx, cfg_data
//
// A new item is taken once the sequencer has run all its slots, one per mode and padded
// to the length of each mode's history read-modify-write loop. The delay memory serves
// one mode per cycle; the previous item may still be in the datapath when the next enters.
// Reset needs no clearing pass: a fill count masks delay entries not yet written.
// A four-entry result queue lets items keep flowing while out_stall is high, until four items are in flight.
module banded_waveguide_three_mode_core #(
  parameter int DELAY_DEPTH = bwg3m_pkg::DEF_DELAY_DEPTH,
  parameter int MODE_COUNT  = bwg3m_pkg::DEF_MODE_COUNT
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [bwg3m_pkg::IN_W-1:0]     in_sample,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [bwg3m_pkg::Q_W-1:0]      out_sample,
  input  logic                                  cfg_we,
  input  logic [bwg3m_pkg::CFG_IDX_W-1:0]       cfg_idx,
  input  logic [bwg3m_pkg::CFG_W-1:0]           cfg_data
);

  localparam int PW      = $clog2(DELAY_DEPTH);
  localparam int MW      = (MODE_COUNT > 1) ? $clog2(MODE_COUNT) : 1;
  localparam int ISSUE_P = (MODE_COUNT > bwg3m_pkg::LOOP_CYC) ? MODE_COUNT
                                                             : bwg3m_pkg::LOOP_CYC;
  localparam int SW      = $clog2(ISSUE_P);
  localparam int EW      = (PW > bwg3m_pkg::DELAY_W) ? PW : bwg3m_pkg::DELAY_W;
  localparam int IN_W    = bwg3m_pkg::IN_W;
  localparam int Q_W     = bwg3m_pkg::Q_W;
  localparam int C_W     = bwg3m_pkg::COEF_W;
  localparam int OCW     = bwg3m_pkg::OUT_CNT_W;

  // config registers
  logic [bwg3m_pkg::CFG_W-1:0]   coef_r    [MODE_COUNT];
  logic [bwg3m_pkg::DELAY_W-1:0] dly_len_r [MODE_COUNT];
  logic [bwg3m_pkg::FB_W-1:0]    fb_r;

  // item state
  logic signed [IN_W-1:0]              x1_r;
  logic signed [IN_W-1:0]              x2_r;
  logic [PW-1:0]                       pos_r;
  logic [PW:0]                         fill_r;
  logic signed [bwg3m_pkg::DIFF_W-1:0] diff_r;
  logic [PW-1:0]                       ipos_r;
  logic [PW:0]                         ifill_r;
  logic signed [IN_W:0]                dx;

  // sequencer
  logic                  active_r;
  logic [SW-1:0]         slot_r;
  logic                  seq_free;
  logic                  accept;
  logic                  iss_vld;
  logic [MW-1:0]         iss_mode;
  bwg3m_pkg::mode_ctl_t  iss_ctl;

  // read address
  logic [EW-1:0]         d_ext;
  logic [EW-1:0]         d_cl;
  logic [PW-1:0]         d_pw;
  logic [PW-1:0]         rd_idx;
  logic                  rd_ok;
  logic [bwg3m_pkg::CFG_W-1:0] coef_sel;

  // result queue
  bwg3m_pkg::result_t    res;
  logic signed [Q_W-1:0] oq_mem [bwg3m_pkg::OUT_DEPTH];
  logic [bwg3m_pkg::OUT_PTR_W-1:0] oq_wp_r;
  logic [bwg3m_pkg::OUT_PTR_W-1:0] oq_rp_r;
  logic [OCW-1:0]        oq_cnt_r;
  logic [OCW-1:0]        inflight_r;
  logic                  pop;

  for (genvar g = 0; g < MODE_COUNT; g++) begin : g_mode
    if (g < bwg3m_pkg::CFG_MODES) begin : g_loaded
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          coef_r[g]    <= '0;
          dly_len_r[g] <= '0;
        end else if (cfg_we) begin
          if (cfg_idx == bwg3m_pkg::CFG_IDX_W'(bwg3m_pkg::CFG_MODE0 + g)) begin
            coef_r[g] <= cfg_data;
          end
          if (cfg_idx == bwg3m_pkg::CFG_DELAYS) begin
            dly_len_r[g] <= cfg_data[bwg3m_pkg::DELAY_W*g +: bwg3m_pkg::DELAY_W];
          end
        end
      end
    end else begin : g_unreached
      // no register reaches these modes
      assign coef_r[g]    = '0;
      assign dly_len_r[g] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fb_r <= bwg3m_pkg::FB_RESET;
    end else if (cfg_we && cfg_idx == bwg3m_pkg::CFG_FB_GAIN) begin
      fb_r <= cfg_data[bwg3m_pkg::FB_W-1:0];
    end
  end

  // handshake
  assign seq_free = !active_r || (slot_r == SW'(ISSUE_P - 1));
  assign in_stall = !seq_free || (inflight_r == OCW'(bwg3m_pkg::OUT_DEPTH));
  assign accept   = in_valid && !in_stall;

  assign dx = (IN_W+1)'(in_sample) - (IN_W+1)'(x2_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x1_r   <= '0;
      x2_r   <= '0;
      pos_r  <= '0;
      fill_r <= '0;
    end else if (accept) begin
      x1_r   <= in_sample;
      x2_r   <= x1_r;
      pos_r  <= (pos_r == PW'(DELAY_DEPTH - 1)) ? '0 : pos_r + 1'b1;
      if (fill_r != (PW+1)'(DELAY_DEPTH)) begin
        fill_r <= fill_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      diff_r  <= {dx, 5'b0};
      ipos_r  <= pos_r;
      ifill_r <= fill_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      slot_r   <= '0;
    end else if (accept) begin
      active_r <= 1'b1;
      slot_r   <= '0;
    end else if (active_r) begin
      if (slot_r == SW'(ISSUE_P - 1)) begin
        active_r <= 1'b0;
      end else begin
        slot_r <= slot_r + 1'b1;
      end
    end
  end

  // one mode per slot, idle slots pad the history loop
  assign iss_vld       = active_r && ((SW+1)'(slot_r) < (SW+1)'(MODE_COUNT));
  assign iss_mode      = slot_r[MW-1:0];
  assign iss_ctl.vld   = iss_vld;
  assign iss_ctl.first = (iss_mode == '0);
  assign iss_ctl.last  = (iss_mode == MW'(MODE_COUNT - 1));

  // clamp long delays, then wrap the read index
  assign d_ext  = EW'(dly_len_r[iss_mode]);
  assign d_cl   = (d_ext > EW'(DELAY_DEPTH - 1)) ? EW'(DELAY_DEPTH - 1) : d_ext;
  assign d_pw   = d_cl[PW-1:0];
  assign rd_idx = ipos_r - d_pw + ((ipos_r < d_pw) ? PW'(DELAY_DEPTH) : '0);
  assign rd_ok  = ((PW+1)'(rd_idx) < ifill_r);

  assign coef_sel = coef_r[iss_mode];

  bwg3m_mode_dp #(
    .DELAY_DEPTH (DELAY_DEPTH),
    .MODE_COUNT  (MODE_COUNT)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl_i    (iss_ctl),
    .mode_i   (iss_mode),
    .rd_idx_i (rd_idx),
    .wr_idx_i (ipos_r),
    .rd_ok_i  (rd_ok),
    .diff_i   (diff_r),
    .a0_i     ($signed(coef_sel[C_W-1:0])),
    .c1_i     ($signed(coef_sel[2*C_W-1:C_W])),
    .c2_i     ($signed(coef_sel[3*C_W-1:2*C_W])),
    .fb_i     (fb_r),
    .res_o    (res)
  );

  // result queue
  assign out_valid  = (oq_cnt_r != '0);
  assign out_sample = oq_mem[oq_rp_r];
  assign pop        = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (res.vld) begin
      oq_mem[oq_wp_r] <= res.sample;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oq_wp_r    <= '0;
      oq_rp_r    <= '0;
      oq_cnt_r   <= '0;
      inflight_r <= '0;
    end else begin
      if (res.vld) begin
        oq_wp_r <= oq_wp_r + 1'b1;
      end
      if (pop) begin
        oq_rp_r <= oq_rp_r + 1'b1;
      end
      case ({res.vld, pop})
        2'b10:   oq_cnt_r <= oq_cnt_r + 1'b1;
        2'b01:   oq_cnt_r <= oq_cnt_r - 1'b1;
        default: oq_cnt_r <= oq_cnt_r;
      endcase
      case ({accept, pop})
        2'b10:   inflight_r <= inflight_r + 1'b1;
        2'b01:   inflight_r <= inflight_r - 1'b1;
        default: inflight_r <= inflight_r;
      endcase
    end
  end

  a_inflight_max: assert property (@(posedge clk) disable iff (!rst_n)
    inflight_r <= OCW'(bwg3m_pkg::OUT_DEPTH))
    else $error("too many items in flight");

  a_queue_le_inflight: assert property (@(posedge clk) disable iff (!rst_n)
    oq_cnt_r <= inflight_r)
    else $error("queue holds more results than accepted items");

  a_queue_no_ovf: assert property (@(posedge clk) disable iff (!rst_n)
    res.vld |-> (oq_cnt_r != OCW'(bwg3m_pkg::OUT_DEPTH)))
    else $error("result queue overflow");

  a_issue_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (iss_vld && iss_mode == '0))
    else $error("accepted item did not start issuing");

endmodule

/* rtl/bwg3m_mode_dp.sv */
// Time-shared mode datapath: delay and history memories, resonator and feedback arithmetic.
module bwg3m_mode_dp #(
  parameter int DELAY_DEPTH = bwg3m_pkg::DEF_DELAY_DEPTH,
  parameter int MODE_COUNT  = bwg3m_pkg::DEF_MODE_COUNT,
  localparam int PW         = $clog2(DELAY_DEPTH),
  localparam int MW         = (MODE_COUNT > 1) ? $clog2(MODE_COUNT) : 1
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  bwg3m_pkg::mode_ctl_t                   ctl_i,
  input  logic [MW-1:0]                          mode_i,
  input  logic [PW-1:0]                          rd_idx_i,
  input  logic [PW-1:0]                          wr_idx_i,
  input  logic                                   rd_ok_i,
  input  logic signed [bwg3m_pkg::DIFF_W-1:0]    diff_i,
  input  logic signed [bwg3m_pkg::COEF_W-1:0]    a0_i,
  input  logic signed [bwg3m_pkg::COEF_W-1:0]    c1_i,
  input  logic signed [bwg3m_pkg::COEF_W-1:0]    c2_i,
  input  logic [bwg3m_pkg::FB_W-1:0]             fb_i,
  output bwg3m_pkg::result_t                     res_o
);

  localparam int MEM_DEPTH = MODE_COUNT * DELAY_DEPTH;
  localparam int AW        = $clog2(MEM_DEPTH);
  localparam int Q_W       = bwg3m_pkg::Q_W;
  localparam int C_W       = bwg3m_pkg::COEF_W;
  localparam int D_W       = bwg3m_pkg::DIFF_W;
  localparam int F_W       = bwg3m_pkg::FB_W;
  localparam int A_W       = bwg3m_pkg::ACC_W;
  localparam int S_W       = bwg3m_pkg::SUM_W;

  // memories
  logic signed [Q_W-1:0]   dly_mem [MEM_DEPTH];
  logic [2*Q_W-1:0]        hist_mem [MODE_COUNT];
  logic [MODE_COUNT-1:0]   hist_vld_r;
  logic signed [Q_W-1:0]   dly_q;
  logic [2*Q_W-1:0]        hist_q;

  logic [AW-1:0]           rd_addr;
  logic [AW-1:0]           wr_addr;

  // stage 1
  bwg3m_pkg::mode_ctl_t    s1_ctl_r;
  logic [MW-1:0]           s1_mode_r;
  logic [AW-1:0]           s1_wa_r;
  logic                    s1_rdok_r;
  logic                    s1_hok_r;
  logic signed [D_W-1:0]   s1_diff_r;
  logic signed [C_W-1:0]   s1_a0_r;
  logic signed [C_W-1:0]   s1_c1_r;
  logic signed [C_W-1:0]   s1_c2_r;
  logic [F_W-1:0]          s1_fb_r;

  logic signed [Q_W-1:0]   vin;
  logic signed [Q_W-1:0]   y1;
  logic signed [Q_W-1:0]   y2;
  logic signed [C_W+D_W-1:0] pa;
  logic signed [C_W+Q_W-1:0] pc1;
  logic signed [C_W+Q_W-1:0] pc2;
  logic signed [F_W+Q_W:0]   pf;

  // stage 2
  bwg3m_pkg::mode_ctl_t    s2_ctl_r;
  logic [MW-1:0]           s2_mode_r;
  logic [AW-1:0]           s2_wa_r;
  logic signed [Q_W-1:0]   s2_y1_r;
  logic signed [C_W+D_W-1:0] s2_pa_r;
  logic signed [C_W+Q_W-1:0] s2_pc1_r;
  logic signed [C_W+Q_W-1:0] s2_pc2_r;
  logic signed [F_W+Q_W:0]   s2_pf_r;

  logic signed [A_W-1:0]   acc;
  logic signed [S_W-1:0]   fbt_full;

  // stage 3
  bwg3m_pkg::mode_ctl_t    s3_ctl_r;
  logic [MW-1:0]           s3_mode_r;
  logic [AW-1:0]           s3_wa_r;
  logic signed [Q_W-1:0]   s3_y1_r;
  logic signed [Q_W-1:0]   s3_y_r;
  logic signed [Q_W:0]     s3_fbt_r;

  logic signed [Q_W-1:0]   ms;
  logic signed [S_W-1:0]   tot_r;
  logic signed [S_W-1:0]   tot_nxt;
  logic                    res_vld_r;
  logic signed [Q_W-1:0]   res_smp_r;

  // each mode owns one region of DELAY_DEPTH entries
  assign rd_addr = AW'(mode_i) * AW'(DELAY_DEPTH) + AW'(rd_idx_i);
  assign wr_addr = AW'(mode_i) * AW'(DELAY_DEPTH) + AW'(wr_idx_i);

  always_ff @(posedge clk) begin
    if (s3_ctl_r.vld) begin
      dly_mem[s3_wa_r]    <= ms;
      hist_mem[s3_mode_r] <= {s3_y1_r, s3_y_r};
    end
    if (ctl_i.vld) begin
      dly_q  <= dly_mem[rd_addr];
      hist_q <= hist_mem[mode_i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_vld_r <= '0;
    end else if (s3_ctl_r.vld) begin
      hist_vld_r[s3_mode_r] <= 1'b1;
    end
  end

  // stage 1 registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_ctl_r <= '0;
    end else begin
      s1_ctl_r <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl_i.vld) begin
      s1_mode_r <= mode_i;
      s1_wa_r   <= wr_addr;
      s1_rdok_r <= rd_ok_i;
      s1_hok_r  <= hist_vld_r[mode_i];
      s1_diff_r <= diff_i;
      s1_a0_r   <= a0_i;
      s1_c1_r   <= c1_i;
      s1_c2_r   <= c2_i;
      s1_fb_r   <= fb_i;
    end
  end

  // unwritten entries read as zero
  assign vin = s1_rdok_r ? dly_q : '0;
  assign y1  = s1_hok_r ? hist_q[Q_W-1:0] : '0;
  assign y2  = s1_hok_r ? hist_q[2*Q_W-1:Q_W] : '0;

  assign pa  = s1_a0_r * s1_diff_r;
  assign pc1 = s1_c1_r * y1;
  assign pc2 = s1_c2_r * y2;
  assign pf  = $signed({1'b0, s1_fb_r}) * vin;

  // stage 2 registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_ctl_r <= '0;
    end else begin
      s2_ctl_r <= s1_ctl_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ctl_r.vld) begin
      s2_mode_r <= s1_mode_r;
      s2_wa_r   <= s1_wa_r;
      s2_y1_r   <= y1;
      s2_pa_r   <= pa;
      s2_pc1_r  <= pc1;
      s2_pc2_r  <= pc2;
      s2_pf_r   <= pf;
    end
  end

  assign acc      = A_W'(s2_pa_r) + A_W'(s2_pc1_r) - A_W'(s2_pc2_r);
  assign fbt_full = bwg3m_pkg::round_q(A_W'(s2_pf_r));

  // stage 3 registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_ctl_r <= '0;
    end else begin
      s3_ctl_r <= s2_ctl_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ctl_r.vld) begin
      s3_mode_r <= s2_mode_r;
      s3_wa_r   <= s2_wa_r;
      s3_y1_r   <= s2_y1_r;
      s3_y_r    <= bwg3m_pkg::sat_q(bwg3m_pkg::round_q(acc));
      s3_fbt_r  <= fbt_full[Q_W:0];
    end
  end

  assign ms      = bwg3m_pkg::sat_q(S_W'(s3_y_r) + S_W'(s3_fbt_r));
  assign tot_nxt = (s3_ctl_r.first ? '0 : tot_r) + S_W'(ms);

  always_ff @(posedge clk) begin
    if (s3_ctl_r.vld) begin
      tot_r <= tot_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_vld_r <= 1'b0;
    end else begin
      res_vld_r <= s3_ctl_r.vld && s3_ctl_r.last;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_ctl_r.vld && s3_ctl_r.last) begin
      res_smp_r <= bwg3m_pkg::sat_q(tot_nxt);
    end
  end

  assign res_o = {res_vld_r, res_smp_r};

  // a mode must not be re-read while its previous update is in stage 2 or stage 3
  a_gap_s3: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl_i.vld && s3_ctl_r.vld) |-> (mode_i != s3_mode_r))
    else $error("history read overlaps write-back of same mode");

  a_gap_s2: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl_i.vld && s2_ctl_r.vld) |-> (mode_i != s2_mode_r))
    else $error("history read overlaps stage 2 of same mode");

  a_res_src: assert property (@(posedge clk) disable iff (!rst_n)
    res_vld_r |-> $past(s3_ctl_r.vld && s3_ctl_r.last))
    else $error("result without a last mode");

endmodule

/* tb/sv/bwg3m_voice_checker.sv */
// Checker for the three-mode waveguide core: tracks config, predicts each output sample, compares.
`timescale 1ns / 100ps

module bwg3m_voice_checker (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic                              in_stall,
  input  logic signed [bwg3m_pkg::IN_W-1:0] in_sample,
  input  logic                              out_valid,
  input  logic                              out_stall,
  input  logic signed [bwg3m_pkg::Q_W-1:0]  out_sample,
  input  logic                              cfg_we,
  input  logic [bwg3m_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [bwg3m_pkg::CFG_W-1:0]       cfg_data,
  output int                                fail_count,
  output int                                pending
);

  localparam int IN_W     = bwg3m_pkg::IN_W;
  localparam int Q_W      = bwg3m_pkg::Q_W;
  localparam int COEF_W   = bwg3m_pkg::COEF_W;
  localparam int DELAY_W  = bwg3m_pkg::DELAY_W;
  localparam int FB_W     = bwg3m_pkg::FB_W;
  localparam int VOICES   = bwg3m_pkg::DEF_MODE_COUNT;
  localparam int LINE_LEN = bwg3m_pkg::DEF_DELAY_DEPTH;
  localparam int REPORT_MAX = 10;
  localparam longint Q_TOP = 64'sd8388607;
  localparam longint Q_BOT = -64'sd8388608;

  logic signed [COEF_W-1:0] gain_c [VOICES];
  logic signed [COEF_W-1:0] c1_c   [VOICES];
  logic signed [COEF_W-1:0] c2_c   [VOICES];
  logic        [DELAY_W-1:0] lag   [VOICES];
  logic        [FB_W-1:0]    fb_gain;

  logic signed [IN_W-1:0] x_d1, x_d2;
  logic signed [Q_W-1:0]  y_d1 [VOICES];
  logic signed [Q_W-1:0]  y_d2 [VOICES];
  logic signed [Q_W-1:0]  line_mem [VOICES*LINE_LEN];
  logic [DELAY_W-1:0]     wr_pos;

  logic signed [Q_W-1:0] expected_samples [$];
  logic signed [Q_W-1:0] want, mix;
  int fails;

  function automatic logic signed [Q_W-1:0] clip_q(input longint v);
    if (v > Q_TOP) begin
      return Q_W'(Q_TOP);
    end else if (v < Q_BOT) begin
      return Q_W'(Q_BOT);
    end
    return Q_W'(v);
  endfunction

  // 36 fraction bits down to 20, round half up (>>> floors on signed)
  function automatic longint to_q20(input longint v);
    return (v + 64'sd32768) >>> 16;
  endfunction

  task automatic voice_step(input logic signed [IN_W-1:0] x,
                            output logic signed [Q_W-1:0] sum_out);
    longint diff, acc, total;
    logic signed [Q_W-1:0] y, tap, s;
    logic [DELAY_W-1:0] rd;
    int m;
    diff  = (longint'(x) - longint'(x_d2)) * 32;
    total = 0;
    for (m = 0; m < VOICES; m++) begin
      // 13-bit wrap; a zero lag reads the slot before it is overwritten
      rd  = wr_pos - lag[m];
      tap = line_mem[m*LINE_LEN + int'(rd)];
      acc = longint'(gain_c[m]) * diff
          + longint'(c1_c[m]) * longint'(y_d1[m])
          - longint'(c2_c[m]) * longint'(y_d2[m]);
      y = clip_q(to_q20(acc));
      s = clip_q(longint'(y) + to_q20(longint'(fb_gain) * longint'(tap)));
      line_mem[m*LINE_LEN + int'(wr_pos)] = s;
      y_d2[m] = y_d1[m];
      y_d1[m] = y;
      total += longint'(s);
    end
    sum_out = clip_q(total);
    x_d2   = x_d1;
    x_d1   = x;
    wr_pos = wr_pos + 1'b1;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int m = 0; m < VOICES; m++) begin
        gain_c[m] = '0;
        c1_c[m]   = '0;
        c2_c[m]   = '0;
        lag[m]    = '0;
        y_d1[m]   = '0;
        y_d2[m]   = '0;
      end
      for (int i = 0; i < VOICES*LINE_LEN; i++) line_mem[i] = '0;
      fb_gain = bwg3m_pkg::FB_RESET;
      x_d1    = '0;
      x_d2    = '0;
      wr_pos  = '0;
      fails   = 0;
      expected_samples.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_samples.size() == 0) begin
          fails++;
          if (fails <= REPORT_MAX) $display("unexpected output item: out_sample %0d", out_sample);
        end else begin
          want = expected_samples.pop_front();
          if (out_sample !== want) begin
            fails++;
            if (fails <= REPORT_MAX) begin
              $display("out_sample mismatch: expected %0d, got %0d", want, out_sample);
            end
          end
        end
      end
      if (cfg_we) begin
        case (cfg_idx)
          bwg3m_pkg::CFG_MODE0, bwg3m_pkg::CFG_MODE1, bwg3m_pkg::CFG_MODE2: begin
            gain_c[cfg_idx[1:0]] = cfg_data[COEF_W-1:0];
            c1_c[cfg_idx[1:0]]   = cfg_data[2*COEF_W-1:COEF_W];
            c2_c[cfg_idx[1:0]]   = cfg_data[3*COEF_W-1:2*COEF_W];
          end
          bwg3m_pkg::CFG_DELAYS: begin
            for (int m = 0; m < VOICES; m++) lag[m] = cfg_data[m*DELAY_W +: DELAY_W];
          end
          bwg3m_pkg::CFG_FB_GAIN: begin
            fb_gain = cfg_data[FB_W-1:0];
          end
          default: ;  // no register behind this index
        endcase
      end
      if (in_valid && !in_stall) begin
        voice_step(in_sample, mix);
        expected_samples.push_back(mix);
      end
    end
    pending    <= expected_samples.size();
    fail_count <= fails;
  end

endmodule

/* tb/sv/tb_top.sv */
// Testbench top: clock, reset, config phases and sample stimulus for the waveguide core.
`timescale 1ns / 100ps

module tb_top;

  localparam int IN_W      = bwg3m_pkg::IN_W;
  localparam int Q_W       = bwg3m_pkg::Q_W;
  localparam int CFG_IDX_W = bwg3m_pkg::CFG_IDX_W;
  localparam int CFG_W     = bwg3m_pkg::CFG_W;
  localparam int DELAY_W   = bwg3m_pkg::DELAY_W;
  localparam int FB_W      = bwg3m_pkg::FB_W;

  typedef enum {VK_TUNED, VK_RAW, VK_POS_LIMIT, VK_NEG_LIMIT, VK_WRAP} voice_kind_t;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int IDLE_PCT     = 23;
  localparam int PHASE_ITEMS  = 140;
  localparam int WRAP_ITEMS   = 160;
  localparam int HOLD_CYCLES  = 150;
  localparam int TAIL_CYCLES  = 2 * (bwg3m_pkg::DEF_MODE_COUNT + 5) + 4;
  localparam int N_PHASES     = 8;
  localparam voice_kind_t PHASE_PLAN [N_PHASES] = '{VK_RAW, VK_POS_LIMIT, VK_TUNED, VK_NEG_LIMIT,
                                                    VK_TUNED, VK_RAW, VK_TUNED, VK_TUNED};
  localparam bwg3m_pkg::cfg_idx_t MODE_REGS [3] = '{bwg3m_pkg::CFG_MODE0, bwg3m_pkg::CFG_MODE1,
                                                    bwg3m_pkg::CFG_MODE2};

  logic                   clk;
  logic                   rst_n;
  logic                   in_valid;
  logic                   in_stall;
  logic signed [IN_W-1:0] in_sample;
  logic                   out_valid;
  logic                   out_stall;
  logic signed [Q_W-1:0]  out_sample;
  logic                   cfg_we;
  logic [CFG_IDX_W-1:0]   cfg_idx;
  logic [CFG_W-1:0]       cfg_data;

  int  fail_count, pending;
  int  cycle_count;
  logic quiet;
  int  hold_reqs;

  // extremes, sign flips, bit patterns
  int seed_vals [] = '{32767, -32768, 0, -1, 1, 32767, 32767, -32768, -32768, 0, 0,
                       21845, -21846, 256, -256, 32767, 0, -32768, 0, 1, -1, 12345};

  banded_waveguide_three_mode_core u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_sample  (in_sample),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_sample (out_sample),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_data   (cfg_data)
  );

  bwg3m_voice_checker u_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_sample  (in_sample),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_sample (out_sample),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // output side: random stalls, plus a long hold-off on request
  initial begin
    int hold_left, holds_done;
    hold_left  = 0;
    holds_done = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (hold_reqs != holds_done) begin
        holds_done++;
        hold_left = HOLD_CYCLES;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !quiet && ($urandom_range(99) < IDLE_PCT);
      end
    end
  end

  task automatic reg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we   <= 1'b0;
  endtask

  // stable two-pole settings: R^2 below one, |2Rcos| below 1 + R^2, poles inside the unit circle
  function automatic logic [CFG_W-1:0] tuned_coeffs();
    int a0, c1, c2;
    c2 = $urandom_range(65500, 50000);
    c1 = int'($urandom_range(220000)) - 110000;
    a0 = int'($urandom_range(12000)) - 6000;
    return {18'(c2), 18'(c1), 18'(a0)};
  endfunction

  function automatic logic [CFG_W-1:0] raw_bits();
    logic [63:0] r;
    r = {$urandom(), $urandom()};
    return r[CFG_W-1:0];
  endfunction

  task automatic load_voice(input voice_kind_t kind, input bit keep_fb);
    logic [CFG_W-1:0]   coef;
    logic [DELAY_W-1:0] d [3];
    logic [FB_W-1:0]    fb;
    logic [CFG_W-1:0]   r;
    int m;
    for (m = 0; m < 3; m++) begin
      case (kind)
        VK_RAW:       coef = raw_bits();
        VK_POS_LIMIT: coef = {3{18'h1FFFF}};
        VK_NEG_LIMIT: coef = {3{18'h20000}};
        default:      coef = tuned_coeffs();
      endcase
      reg_write(MODE_REGS[m], coef);
      r = raw_bits();
      case (kind)
        VK_RAW:       d[m] = r[DELAY_W-1:0];
        VK_POS_LIMIT: d[m] = '1;
        VK_NEG_LIMIT: d[m] = '0;
        VK_WRAP:      d[m] = (m == 0) ? '0 : ((m == 1) ? DELAY_W'(1) : '1);
        default:      d[m] = ($urandom_range(3) == 0) ? DELAY_W'($urandom_range(8191))
                                                      : DELAY_W'($urandom_range(400));
      endcase
    end
    reg_write(bwg3m_pkg::CFG_DELAYS, {d[2], d[1], d[0]});
    case (kind)
      VK_RAW:       fb = FB_W'($urandom());
      VK_NEG_LIMIT: fb = '0;
      VK_TUNED:     fb = FB_W'($urandom_range(65535, 60000));
      default:      fb = '1;
    endcase
    if (!keep_fb) reg_write(bwg3m_pkg::CFG_FB_GAIN, fb);
    // a write past the last register must change nothing
    reg_write(CFG_IDX_W'($urandom_range(2**CFG_IDX_W - 1, int'(bwg3m_pkg::CFG_FB_GAIN) + 1)),
              raw_bits());
  endtask

  task automatic send_item(input logic signed [IN_W-1:0] s);
    if (!quiet && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < IDLE_PCT) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_sample <= s;
    do @(posedge clk); while (in_stall);
  endtask

  function automatic logic signed [IN_W-1:0] pick_sample();
    case ($urandom_range(9))
      0:       return 16'sh7FFF;
      1:       return 16'sh8000;
      2, 3:    return IN_W'(int'($urandom_range(64)) - 32);
      default: return IN_W'($urandom());
    endcase
  endfunction

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    in_valid  <= 1'b0;
    in_sample <= '0;
    cfg_we    <= 1'b0;
    cfg_idx   <= '0;
    cfg_data  <= '0;
    quiet     <= 1'b0;
    hold_reqs <= 0;
    rst_n     <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed items run on the reset feedback gain
    load_voice(VK_TUNED, 1'b1);
    foreach (seed_vals[i]) send_item(IN_W'(seed_vals[i]));
    drain();

    for (int p = 0; p < N_PHASES; p++) begin
      load_voice(PHASE_PLAN[p], 1'b0);
      quiet <= (p == 4);
      if (p == 2) hold_reqs <= hold_reqs + 1;
      for (int i = 0; i < PHASE_ITEMS; i++) send_item(pick_sample());
      drain();
    end

    // zero, one-sample and full-length lags side by side
    load_voice(VK_WRAP, 1'b0);
    for (int i = 0; i < WRAP_ITEMS; i++) begin
      quiet <= (i < WRAP_ITEMS / 2);
      send_item(pick_sample());
    end
    drain();
    quiet <= 1'b0;

    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
